/* design/first_fit_heap_allocator_assert.svh */
// Assertion macros used by the heap allocator datapath.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, sampled on aclk, off while aresetn is low.
`define FFHA_CHECK(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("first_fit_heap_allocator: check failed");

// Next-cycle implication, sampled on aclk, off while aresetn is low.
`define FFHA_CHECK_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("first_fit_heap_allocator: sequence check failed");

`endif

/* design/ffha_pkg.sv */
// Types, constants and microprogram of the first-fit heap allocator.
package ffha_pkg;

    localparam int HEAP_BYTES = 4096;
    localparam int HEAP_SPAN  = HEAP_BYTES - (HEAP_BYTES % 8);
    localparam int GRANULES   = HEAP_SPAN / 8;
    localparam int GA_W       = $clog2(GRANULES);
    localparam int G_W        = $clog2(GRANULES + 1);
    localparam int SG_W       = GA_W;
    localparam int REQ_W      = 16;
    localparam int OFF_W      = 16;
    localparam int NG_W       = REQ_W - 2;
    localparam int PAY_W      = 12;
    localparam int LIVE_W     = G_W;
    localparam int LIVE_OUT_W = 10;
    localparam int STATUS_W   = 2;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK,
        STATUS_NO_SPACE,
        STATUS_BAD_POINTER
    } status_t;

    // Chunk header as kept in the header RAM, size counted in granules.
    typedef struct packed {
        logic            alloc;
        logic [SG_W-1:0] size;
    } hdr_t;

    typedef enum logic [4:0] {
        S_INIT, S_IDLE, S_DISPATCH,
        S_A_RD, S_A_EV, S_A_HIT, S_A_SPL, S_A_OK, S_A_FAIL,
        S_F_CHK, S_F_RD, S_F_EV, S_F_TEST, S_F_CLR,
        S_M_RD, S_M_EV, S_M_NX,
        S_F_OK, S_F_BAD, S_DONE
    } step_t;

    typedef enum logic [3:0] {
        C_ALWAYS, C_START, C_CMD_FREE, C_LOC_END, C_FIT, C_EXACT, C_OFF_BAD,
        C_PAST_TGT, C_AT_TGT, C_CUR_ALLOC, C_MERGE_GO, C_RD_ALLOC, C_OUT_FREE
    } cond_t;

    typedef enum logic [1:0] {LOC_HOLD, LOC_ZERO, LOC_CALC, LOC_NXT} loc_op_t;
    typedef enum logic [2:0] {
        WR_NONE, WR_INIT, WR_GRANT, WR_SPLIT, WR_CLEAR, WR_MERGE
    } wr_op_t;
    typedef enum logic [1:0] {RD_NONE, RD_LOC, RD_CALC} rd_op_t;
    typedef enum logic [2:0] {ST_HOLD, ST_GRANT, ST_NOSPACE, ST_FREED, ST_BAD} st_op_t;
    typedef enum logic [1:0] {LV_HOLD, LV_INC, LV_DEC} live_op_t;

    // One microinstruction: a two-way branch with actions on each arm.
    typedef struct packed {
        cond_t    cond;
        step_t    jmp_t;
        step_t    jmp_f;
        loc_op_t  loc_t;
        loc_op_t  loc_f;
        wr_op_t   wr_t;
        wr_op_t   wr_f;
        rd_op_t   rd;
        logic     cap;
        st_op_t   st;
        live_op_t live;
        logic     take;
        logic     emit;
    } word_t;

    // Resolved controls sent to the datapath.
    typedef struct packed {
        rd_op_t   rd;
        loc_op_t  loc;
        wr_op_t   wr;
        logic     cap;
        st_op_t   st;
        live_op_t live;
        logic     take;
        logic     emit;
    } ctrl_t;

    // Datapath conditions seen by the sequencer.
    typedef struct packed {
        logic start;
        logic cmd_free;
        logic loc_end;
        logic fit;
        logic exact;
        logic off_bad;
        logic past_tgt;
        logic at_tgt;
        logic cur_alloc;
        logic merge_go;
        logic rd_alloc;
        logic out_free;
    } flags_t;

    localparam word_t NOP_WORD = '{
        cond: C_ALWAYS, jmp_t: S_IDLE, jmp_f: S_IDLE,
        loc_t: LOC_HOLD, loc_f: LOC_HOLD, wr_t: WR_NONE, wr_f: WR_NONE,
        rd: RD_NONE, cap: 1'b0, st: ST_HOLD, live: LV_HOLD,
        take: 1'b0, emit: 1'b0
    };

    function automatic word_t ucode(input step_t s);
        word_t w;
        w = NOP_WORD;
        case (s)
            S_INIT: begin
                w.wr_t = WR_INIT;
                w.jmp_t = S_IDLE;
            end
            S_IDLE: begin
                w.cond = C_START; w.take = 1'b1; w.loc_t = LOC_ZERO;
                w.jmp_t = S_DISPATCH; w.jmp_f = S_IDLE;
            end
            S_DISPATCH: begin
                w.cond = C_CMD_FREE; w.jmp_t = S_F_CHK; w.jmp_f = S_A_RD;
            end
            S_A_RD: begin
                w.cond = C_LOC_END; w.rd = RD_LOC;
                w.jmp_t = S_A_FAIL; w.jmp_f = S_A_EV;
            end
            S_A_EV: begin
                w.cond = C_FIT; w.cap = 1'b1; w.loc_f = LOC_CALC;
                w.jmp_t = S_A_HIT; w.jmp_f = S_A_RD;
            end
            S_A_HIT: begin
                w.cond = C_EXACT; w.wr_t = WR_GRANT; w.wr_f = WR_GRANT;
                w.jmp_t = S_A_OK; w.jmp_f = S_A_SPL;
            end
            S_A_SPL: begin
                w.wr_t = WR_SPLIT; w.jmp_t = S_A_OK;
            end
            S_A_OK: begin
                w.st = ST_GRANT; w.live = LV_INC; w.jmp_t = S_DONE;
            end
            S_A_FAIL: begin
                w.st = ST_NOSPACE; w.jmp_t = S_DONE;
            end
            S_F_CHK: begin
                w.cond = C_OFF_BAD; w.jmp_t = S_F_BAD; w.jmp_f = S_F_RD;
            end
            S_F_RD: begin
                w.cond = C_PAST_TGT; w.rd = RD_LOC;
                w.jmp_t = S_F_BAD; w.jmp_f = S_F_EV;
            end
            S_F_EV: begin
                w.cond = C_AT_TGT; w.cap = 1'b1; w.loc_f = LOC_CALC;
                w.jmp_t = S_F_TEST; w.jmp_f = S_F_RD;
            end
            S_F_TEST: begin
                w.cond = C_CUR_ALLOC; w.jmp_t = S_F_CLR; w.jmp_f = S_F_BAD;
            end
            S_F_CLR: begin
                w.wr_t = WR_CLEAR; w.live = LV_DEC; w.loc_t = LOC_ZERO;
                w.jmp_t = S_M_RD;
            end
            S_M_RD: begin
                w.cond = C_LOC_END; w.rd = RD_LOC;
                w.jmp_t = S_F_OK; w.jmp_f = S_M_EV;
            end
            S_M_EV: begin
                w.cond = C_MERGE_GO; w.cap = 1'b1; w.rd = RD_CALC; w.loc_f = LOC_CALC;
                w.jmp_t = S_M_NX; w.jmp_f = S_M_RD;
            end
            S_M_NX: begin
                w.cond = C_RD_ALLOC; w.loc_t = LOC_NXT; w.wr_f = WR_MERGE;
                w.jmp_t = S_M_RD; w.jmp_f = S_M_RD;
            end
            S_F_OK: begin
                w.st = ST_FREED; w.jmp_t = S_DONE;
            end
            S_F_BAD: begin
                w.st = ST_BAD; w.jmp_t = S_DONE;
            end
            S_DONE: begin
                w.cond = C_OUT_FREE; w.emit = 1'b1;
                w.jmp_t = S_IDLE; w.jmp_f = S_DONE;
            end
            default: begin
                w.jmp_t = S_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

/* design/ffha_sequencer.sv */
// Microprogram sequencer: step counter, control ROM and branch select.
module ffha_sequencer
    import ffha_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  flags_t flags,
    output ctrl_t  ctrl
);

    step_t step_reg, step_next;
    word_t word;
    logic  taken;

    always_comb begin
        word = ucode(step_reg);
        case (word.cond)
            C_ALWAYS:    taken = 1'b1;
            C_START:     taken = flags.start;
            C_CMD_FREE:  taken = flags.cmd_free;
            C_LOC_END:   taken = flags.loc_end;
            C_FIT:       taken = flags.fit;
            C_EXACT:     taken = flags.exact;
            C_OFF_BAD:   taken = flags.off_bad;
            C_PAST_TGT:  taken = flags.past_tgt;
            C_AT_TGT:    taken = flags.at_tgt;
            C_CUR_ALLOC: taken = flags.cur_alloc;
            C_MERGE_GO:  taken = flags.merge_go;
            C_RD_ALLOC:  taken = flags.rd_alloc;
            C_OUT_FREE:  taken = flags.out_free;
            default:     taken = 1'b0;
        endcase
    end

    always_comb begin
        step_next = taken ? word.jmp_t : word.jmp_f;
    end

    always_comb begin
        ctrl.rd   = word.rd;
        ctrl.loc  = taken ? word.loc_t : word.loc_f;
        ctrl.wr   = taken ? word.wr_t : word.wr_f;
        ctrl.cap  = word.cap;
        ctrl.st   = word.st;
        ctrl.live = word.live;
        ctrl.take = word.take;
        ctrl.emit = word.emit;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= S_INIT;
        end else begin
            step_reg <= step_next;
        end
    end

endmodule

/* design/ffha_datapath.sv */
// Datapath: header RAM, walk pointer, request latches and result registers.
`include "first_fit_heap_allocator_assert.svh"
module ffha_datapath
    import ffha_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ctrl_t                 ctrl,
    output flags_t                flags,
    input  logic                  s_valid,
    input  logic                  s_command,
    input  logic [REQ_W-1:0]      s_request_bytes,
    input  logic [OFF_W-1:0]      s_release_offset,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [STATUS_W-1:0]   m_status,
    output logic [PAY_W-1:0]      m_payload_offset,
    output logic [LIVE_OUT_W-1:0] m_live_objects
);

    hdr_t mem [GRANULES];
    hdr_t rd_hdr_reg;
    hdr_t cur_hdr_reg;

    logic [G_W-1:0]    loc_reg, loc_next;
    logic [G_W-1:0]    nxt_reg;
    logic [NG_W-1:0]   need_reg;
    logic [G_W-1:0]    tgt_reg;
    logic              off_bad_reg;
    logic              cmd_reg;
    logic [LIVE_W-1:0] live_reg, live_next;
    status_t           status_reg;
    logic [PAY_W-1:0]  pay_reg;

    logic                  m_valid_reg;
    status_t               m_status_reg;
    logic [PAY_W-1:0]      m_pay_reg;
    logic [LIVE_OUT_W-1:0] m_live_reg;

    logic                accept;
    logic                out_free;
    logic [G_W:0]        calc;
    logic [G_W:0]        split_loc;
    logic [REQ_W:0]      req_round;
    logic [OFF_W-4:0]    off_g;
    logic [G_W+2:0]      pay_calc;
    logic                wr_en;
    logic [GA_W-1:0]     wr_addr;
    hdr_t                wr_data;
    logic                rd_en;
    logic [GA_W-1:0]     rd_addr;

    assign accept    = ctrl.take && s_valid;
    assign out_free  = !m_valid_reg || m_ready;
    assign calc      = {1'b0, loc_reg} + (G_W+1)'(rd_hdr_reg.size) + (G_W+1)'(1);
    assign split_loc = {1'b0, loc_reg} + (G_W+1)'(need_reg) + (G_W+1)'(1);
    assign req_round = {1'b0, s_request_bytes} + (REQ_W+1)'(7);
    assign off_g     = s_release_offset[OFF_W-1:3];
    assign pay_calc  = {loc_reg + G_W'(1), 3'b000};

    always_comb begin
        flags.start     = s_valid;
        flags.cmd_free  = (cmd_reg == CMD_FREE);
        flags.loc_end   = (loc_reg >= G_W'(GRANULES));
        flags.fit       = !rd_hdr_reg.alloc && (NG_W'(rd_hdr_reg.size) >= need_reg);
        flags.exact     = (NG_W'(cur_hdr_reg.size) == need_reg);
        flags.off_bad   = off_bad_reg;
        flags.past_tgt  = (loc_reg > tgt_reg);
        flags.at_tgt    = (loc_reg == tgt_reg);
        flags.cur_alloc = cur_hdr_reg.alloc;
        flags.merge_go  = !rd_hdr_reg.alloc && (calc < (G_W+1)'(GRANULES));
        flags.rd_alloc  = rd_hdr_reg.alloc;
        flags.out_free  = out_free;
    end

    // Header RAM write port.
    always_comb begin
        wr_en   = 1'b1;
        wr_addr = loc_reg[GA_W-1:0];
        wr_data = '{alloc: 1'b0, size: cur_hdr_reg.size};
        case (ctrl.wr)
            WR_NONE:  wr_en = 1'b0;
            WR_INIT: begin
                wr_addr = '0;
                wr_data = '{alloc: 1'b0, size: SG_W'(GRANULES - 1)};
            end
            WR_GRANT: wr_data = '{alloc: 1'b1, size: need_reg[SG_W-1:0]};
            WR_SPLIT: begin
                wr_addr = split_loc[GA_W-1:0];
                wr_data = '{alloc: 1'b0,
                            size: cur_hdr_reg.size - need_reg[SG_W-1:0] - SG_W'(1)};
            end
            WR_CLEAR: wr_data = '{alloc: 1'b0, size: cur_hdr_reg.size};
            WR_MERGE: wr_data = '{alloc: 1'b0,
                                  size: cur_hdr_reg.size + rd_hdr_reg.size + SG_W'(1)};
            default:  wr_en = 1'b0;
        endcase
    end

    always_comb begin
        rd_en   = 1'b1;
        rd_addr = loc_reg[GA_W-1:0];
        case (ctrl.rd)
            RD_NONE: rd_en = 1'b0;
            RD_LOC:  rd_addr = loc_reg[GA_W-1:0];
            RD_CALC: rd_addr = calc[GA_W-1:0];
            default: rd_en = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_hdr_reg <= mem[rd_addr];
        end
    end

    always_comb begin
        case (ctrl.loc)
            LOC_HOLD: loc_next = loc_reg;
            LOC_ZERO: loc_next = '0;
            LOC_CALC: loc_next = calc[G_W-1:0];
            LOC_NXT:  loc_next = nxt_reg;
            default:  loc_next = loc_reg;
        endcase
    end

    always_comb begin
        case (ctrl.live)
            LV_HOLD: live_next = live_reg;
            LV_INC:  live_next = live_reg + LIVE_W'(1);
            LV_DEC:  live_next = (live_reg != '0) ? live_reg - LIVE_W'(1) : live_reg;
            default: live_next = live_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        loc_reg <= loc_next;
        if (ctrl.cap) begin
            cur_hdr_reg <= rd_hdr_reg;
            nxt_reg     <= calc[G_W-1:0];
        end
        if (accept) begin
            cmd_reg     <= s_command;
            need_reg    <= req_round[REQ_W:3];
            tgt_reg     <= G_W'(off_g - (OFF_W-3)'(1));
            off_bad_reg <= ({1'b0, s_release_offset} >= (OFF_W+1)'(HEAP_SPAN))
                        || (s_release_offset[2:0] != 3'b000)
                        || (off_g == '0);
        end
        case (ctrl.st)
            ST_HOLD: ;
            ST_GRANT: begin
                status_reg <= STATUS_OK;
                pay_reg    <= PAY_W'(pay_calc);
            end
            ST_NOSPACE: begin
                status_reg <= STATUS_NO_SPACE;
                pay_reg    <= '0;
            end
            ST_FREED: begin
                status_reg <= STATUS_OK;
                pay_reg    <= '0;
            end
            ST_BAD: begin
                status_reg <= STATUS_BAD_POINTER;
                pay_reg    <= '0;
            end
            default: ;
        endcase
        if (ctrl.emit && out_free) begin
            m_status_reg <= status_reg;
            m_pay_reg    <= pay_reg;
            m_live_reg   <= LIVE_OUT_W'(live_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            live_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            live_reg <= live_next;
            if (ctrl.emit && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_payload_offset = m_pay_reg;
    assign m_live_objects   = m_live_reg;

    `FFHA_CHECK(grant_on_free_chunk, ctrl.wr == WR_GRANT, (loc_reg < G_W'(GRANULES)) && !cur_hdr_reg.alloc)
    `FFHA_CHECK(split_leaves_room, ctrl.wr == WR_SPLIT, NG_W'(cur_hdr_reg.size) > need_reg)
    `FFHA_CHECK(merge_two_free, ctrl.wr == WR_MERGE, !rd_hdr_reg.alloc && !cur_hdr_reg.alloc)
    `FFHA_CHECK(release_has_owner, ctrl.live == LV_DEC, live_reg != '0)
    `FFHA_CHECK_NEXT(grant_then_finish, ctrl.wr == WR_GRANT, (ctrl.st == ST_GRANT) || (ctrl.wr == WR_SPLIT))

endmodule

/* design/first_fit_heap_allocator.sv */
// Top level of the first-fit heap allocator: sequencer plus datapath.
//
// First-fit allocator over a 4096-byte heap kept as an implicit list of
// chunks, each led by an 8-byte header (size and allocated mark) held in a
// 512-entry header RAM, one entry per 8-byte granule. An allocate request
// rounds the byte count up to a multiple of 8, walks the chunks from offset
// 0 and takes the first free chunk that fits, whole on an exact match or
// split with a free remainder; otherwise it answers no_space. A free request
// returns bad_pointer, with nothing changed, unless the offset is the
// payload start of an allocated chunk; a good free clears the mark and runs
// one coalescing pass over the whole heap. Every request gets one result
// carrying the status, the granted payload offset (zero unless an allocate
// succeeds) and the count of live chunks. The header RAM has one registered
// read port, so the microprogram visits each chunk in a read step and an
// evaluate step. An allocate walks the chunks up to the hit, at most 512.
// A free walks to its chunk, then the coalescing pass reads every chunk,
// reads on past each free chunk that has a chunk after it, and writes one
// merge for each free neighbour it finds. Requests are handled one at a
// time; a new request is taken as soon as the sequencer is idle, even while
// the previous result still waits in the output register. After reset the
// init step writes the first header before the first request is taken.
module first_fit_heap_allocator
    import ffha_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_command,
    input  logic [REQ_W-1:0]      s_request_bytes,
    input  logic [OFF_W-1:0]      s_release_offset,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [STATUS_W-1:0]   m_status,
    output logic [PAY_W-1:0]      m_payload_offset,
    output logic [LIVE_OUT_W-1:0] m_live_objects
);

    ctrl_t  ctrl;
    flags_t flags;

    // The sequencer steps through the control ROM, picking each branch arm
    // from the datapath flags.
    ffha_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .flags   (flags),
        .ctrl    (ctrl)
    );

    // The datapath holds the header RAM, the walk pointer and the result
    // registers; it latches a request when the idle step sees valid.
    ffha_datapath u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .ctrl             (ctrl),
        .flags            (flags),
        .s_valid          (s_valid),
        .s_command        (s_command),
        .s_request_bytes  (s_request_bytes),
        .s_release_offset (s_release_offset),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_payload_offset (m_payload_offset),
        .m_live_objects   (m_live_objects)
    );

    // Take a request only in the idle step of the microprogram.
    assign s_ready = ctrl.take;

endmodule

/* tb/sv/first_fit_heap_allocator_checker.sv */
// Checker for the first-fit heap allocator: heap predictor and result compare.
`timescale 1ns / 100ps

module first_fit_heap_allocator_checker
    import ffha_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic                  s_command,
    input  logic [REQ_W-1:0]      s_request_bytes,
    input  logic [OFF_W-1:0]      s_release_offset,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic [STATUS_W-1:0]   m_status,
    input  logic [PAY_W-1:0]      m_payload_offset,
    input  logic [LIVE_OUT_W-1:0] m_live_objects,
    output int                    mismatch_count,
    output int                    replies_due
);

    localparam int unsigned HDR = 8;

    typedef struct packed {
        status_t               status;
        logic [PAY_W-1:0]      payload;
        logic [LIVE_OUT_W-1:0] live;
    } reply_t;

    reply_t      replies_owed[$];
    reply_t      oldest;
    int unsigned chunk_bytes[GRANULES];
    bit          chunk_taken[GRANULES];
    int unsigned live_total;

    function automatic int unsigned size_at(input int unsigned loc);
        return ((loc >> 3) < GRANULES) ? chunk_bytes[loc >> 3] : 0;
    endfunction

    function automatic bit taken_at(input int unsigned loc);
        return ((loc >> 3) < GRANULES) ? chunk_taken[loc >> 3] : 1'b0;
    endfunction

    function automatic void put_header(input int unsigned loc, input int unsigned sz,
                                       input bit taken);
        if ((loc >> 3) < GRANULES) begin
            chunk_bytes[loc >> 3] = sz;
            chunk_taken[loc >> 3] = taken;
        end
    endfunction

    function automatic void clear_heap();
        for (int g = 0; g < GRANULES; g++) begin
            chunk_bytes[g] = 0;
            chunk_taken[g] = 1'b0;
        end
        put_header(0, HEAP_SPAN - HDR, 1'b0);
        live_total = 0;
    endfunction

    // Fold every run of adjacent free chunks into its first chunk.
    function automatic void coalesce_heap();
        int unsigned loc, sz, nxt;
        loc = 0;
        while (loc + HDR <= HEAP_SPAN) begin
            sz = size_at(loc);
            nxt = loc + sz + HDR;
            if (!taken_at(loc) && nxt < HEAP_SPAN && !taken_at(nxt)) begin
                put_header(loc, sz + size_at(nxt) + HDR, 1'b0);
            end else begin
                loc = nxt;
            end
        end
    endfunction

    function automatic status_t grant_chunk(input int unsigned bytes,
                                            output int unsigned payload);
        int unsigned need, loc, sz;
        need = (bytes + 7) & ~32'd7;
        loc = 0;
        payload = 0;
        while (loc + HDR <= HEAP_SPAN) begin
            sz = size_at(loc);
            if (!taken_at(loc) && sz >= need) begin
                if (sz == need) begin
                    put_header(loc, sz, 1'b1);
                end else begin
                    put_header(loc, need, 1'b1);
                    put_header(loc + need + HDR, sz - need - HDR, 1'b0);
                end
                live_total++;
                payload = loc + HDR;
                return STATUS_OK;
            end
            loc += sz + HDR;
        end
        return STATUS_NO_SPACE;
    endfunction

    function automatic status_t release_chunk(input int unsigned off);
        int unsigned loc;
        bit hit;
        loc = 0;
        hit = 1'b0;
        if (off >= HEAP_SPAN) return STATUS_BAD_POINTER;
        while (loc + HDR <= HEAP_SPAN) begin
            if (loc + HDR == off) begin
                hit = 1'b1;
                break;
            end
            loc += size_at(loc) + HDR;
        end
        if (!hit || !taken_at(loc)) return STATUS_BAD_POINTER;
        put_header(loc, size_at(loc), 1'b0);
        if (live_total > 0) live_total--;
        coalesce_heap();
        return STATUS_OK;
    endfunction

    function automatic reply_t predict_reply(input logic cmd, input logic [REQ_W-1:0] bytes,
                                             input logic [OFF_W-1:0] off);
        reply_t r;
        int unsigned payload;
        payload = 0;
        if (cmd == CMD_ALLOC) r.status = grant_chunk(32'(bytes), payload);
        else                  r.status = release_chunk(32'(off));
        r.payload = payload[PAY_W-1:0];
        r.live    = live_total[LIVE_OUT_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_heap();
            replies_owed.delete();
            mismatch_count = 0;
            replies_due <= 0;
        end else begin
            if (s_valid && s_ready) begin
                replies_owed.push_back(predict_reply(s_command, s_request_bytes,
                                                     s_release_offset));
            end
            if (m_valid && m_ready) begin
                if (replies_owed.size() == 0) begin
                    report_mismatch("result with none expected", int'(m_status), -1);
                end else begin
                    oldest = replies_owed.pop_front();
                    if (m_status != oldest.status)
                        report_mismatch("status", int'(m_status), int'(oldest.status));
                    if (m_payload_offset != oldest.payload)
                        report_mismatch("payload_offset", int'(m_payload_offset),
                                        int'(oldest.payload));
                    if (m_live_objects != oldest.live)
                        report_mismatch("live_objects", int'(m_live_objects),
                                        int'(oldest.live));
                end
            end
            replies_due <= replies_owed.size();
        end
    end

endmodule

/* tb/sv/tb_first_fit_heap_allocator.sv */
// Testbench top for the first-fit heap allocator: request stimulus and verdict.
`timescale 1ns / 100ps

module tb_first_fit_heap_allocator;
    import ffha_pkg::*;

    localparam int RANDOM_REQUESTS = 450;
    localparam int FILL_CAP        = 48;
    localparam int POOL_HIGH       = 40;
    // A free on a fully fragmented heap runs the longest; leave room
    // for the longest stall on either side on top of that.
    localparam int WATCHDOG_LIMIT  = 20000;
    localparam int DRAIN_CYCLES    = 2200;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_command;
    logic [REQ_W-1:0]      s_request_bytes;
    logic [OFF_W-1:0]      s_release_offset;
    logic                  m_valid;
    logic                  m_ready;
    logic [STATUS_W-1:0]   m_status;
    logic [PAY_W-1:0]      m_payload_offset;
    logic [LIVE_OUT_W-1:0] m_live_objects;

    int mismatch_count;
    int replies_due;
    int idle_cycles;

    // Offsets granted and not yet freed, as seen on the result channel.
    logic [PAY_W-1:0] granted_pool[$];
    logic             cmd_log[$];
    logic             logged_cmd;
    status_t          last_status;
    logic [OFF_W-1:0] last_freed;
    bit               calm;

    first_fit_heap_allocator dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_command        (s_command),
        .s_request_bytes  (s_request_bytes),
        .s_release_offset (s_release_offset),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_payload_offset (m_payload_offset),
        .m_live_objects   (m_live_objects)
    );

    first_fit_heap_allocator_checker checker_inst (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_command        (s_command),
        .s_request_bytes  (s_request_bytes),
        .s_release_offset (s_release_offset),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_payload_offset (m_payload_offset),
        .m_live_objects   (m_live_objects),
        .mismatch_count   (mismatch_count),
        .replies_due      (replies_due)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Gap length: mostly none or short, now and then long; none at all in
    // calm stretches.
    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(20, 150);
    endfunction

    // Request sizes: many tiny ones to fragment the heap, a few huge.
    function automatic logic [REQ_W-1:0] pick_size();
        int r;
        r = $urandom_range(99);
        if (r < 20) return REQ_W'($urandom_range(0, 8));
        if (r < 70) return REQ_W'($urandom_range(1, 64));
        if (r < 90) return REQ_W'($urandom_range(65, 600));
        if (r < 98) return REQ_W'($urandom_range(601, HEAP_BYTES));
        return REQ_W'($urandom);
    endfunction

    // Drive one request at the falling edge and hold it until accepted.
    task automatic send(input logic cmd, input logic [REQ_W-1:0] bytes,
                        input logic [OFF_W-1:0] off);
        @(negedge aclk);
        s_command        <= cmd;
        s_request_bytes  <= bytes;
        s_release_offset <= off;
        s_valid          <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Drop valid for a random gap; with no gap the next request follows at once.
    task automatic pause_sender();
        int n;
        n = pick_gap();
        if (n > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (n - 1) @(negedge aclk);
        end
    endtask

    // The field a command ignores carries random bits.
    task automatic alloc_req(input logic [REQ_W-1:0] bytes);
        send(CMD_ALLOC, bytes, OFF_W'($urandom));
        pause_sender();
    endtask

    task automatic free_req(input logic [OFF_W-1:0] off);
        send(CMD_FREE, REQ_W'($urandom), off);
        pause_sender();
    endtask

    // Release a granted offset picked at random from the pool.
    task automatic free_from_pool();
        int idx;
        idx = $urandom_range(granted_pool.size() - 1);
        last_freed = OFF_W'(granted_pool[idx]);
        granted_pool.delete(idx);
        free_req(last_freed);
    endtask

    // Lower valid and wait until every request has its result.
    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        do @(posedge aclk); while (replies_due != 0);
    endtask

    // Track commands and granted offsets from the result channel so that
    // most frees target live chunks.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) cmd_log.push_back(s_command);
            if (m_valid && m_ready && cmd_log.size() > 0) begin
                logged_cmd = cmd_log.pop_front();
                last_status <= status_t'(m_status);
                if (logged_cmd == CMD_ALLOC && m_status == STATUS_OK)
                    granted_pool.push_back(m_payload_offset);
            end
        end
    end

    // Stall the result side at random; hold ready high through calm stretches.
    initial begin
        int hold;
        hold = 0;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold > 0) begin
                m_ready <= 1'b0;
                hold--;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(7) == 0) hold = pick_gap();
            end
        end
    end

    // Abort when neither channel moves for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        int r;
        s_valid          = 1'b0;
        s_command        = CMD_ALLOC;
        s_request_bytes  = '0;
        s_release_offset = '0;
        aresetn          = 1'b0;
        calm             = 1'b0;
        last_freed       = '0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part: whole-heap grants, oversize requests, splits, exact
        // reuse, every kind of bad pointer and merges on both sides.
        alloc_req(16'd4088);    // exact fit of the whole heap
        alloc_req(16'd0);       // heap full: no space
        free_req(16'd8);
        free_req(16'd8);        // already free
        alloc_req(16'd4096);    // one granule too big
        alloc_req(16'hFFFF);    // largest request
        alloc_req(16'd4081);    // rounds up to the whole heap
        free_req(16'd8);
        alloc_req(16'd0);       // zero bytes splits off an empty chunk
        alloc_req(16'd1);
        alloc_req(16'd7);
        alloc_req(16'd9);
        free_req(16'd0);        // inside heap, never a payload start
        free_req(16'hFFFF);     // outside heap
        free_req(16'd4095);     // last byte of the heap
        free_req(16'd20);       // unaligned
        free_req(16'd16);
        free_req(16'd32);       // merges with the free chunk before it
        alloc_req(16'd24);      // exact fit in the merged chunk
        free_req(16'd48);       // merges with the free tail
        free_req(16'd8);
        alloc_req(16'd0);       // exact fit of an empty chunk
        free_req(16'd16);
        free_req(16'd8);        // merges everything back into one chunk
        free_req(16'd4096);     // first offset past the heap
        settle();
        granted_pool.delete();

        // Random part: mostly grants and frees of live chunks, with some
        // stale, aligned-random and fully random offsets mixed in.
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n % 64 == 0) calm = ($urandom_range(3) == 0);
            r = $urandom_range(99);
            if (granted_pool.size() > POOL_HIGH && r < 45) r = r + 40;
            if (r < 45) begin
                alloc_req(pick_size());
            end else if (r < 85) begin
                if (granted_pool.size() > 0) free_from_pool();
                else alloc_req(pick_size());
            end else if (r < 90) begin
                free_req(last_freed);
            end else if (r < 95) begin
                free_req(OFF_W'($urandom_range(0, HEAP_BYTES - 1)) & ~16'd7);
            end else begin
                free_req(OFF_W'($urandom));
            end
        end
        calm = 1'b0;

        // Empty the heap, take most of it in one chunk that leaves a
        // 33-granule tail, then fill the tail with zero-byte requests until
        // it runs out of headers, one request at a time.
        settle();
        while (granted_pool.size() > 0) free_from_pool();
        settle();
        send(CMD_ALLOC, 16'd3824, OFF_W'($urandom));
        settle();
        for (int k = 0; k < FILL_CAP; k++) begin
            send(CMD_ALLOC, 16'd0, OFF_W'($urandom));
            settle();
            if (last_status == STATUS_NO_SPACE) break;
        end
        free_req(16'd4096);     // payload of the last granule lies past the heap
        if (granted_pool.size() > 0) free_from_pool();

        settle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && replies_due == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+design
design/ffha_pkg.sv
design/ffha_sequencer.sv
design/ffha_datapath.sv
design/first_fit_heap_allocator.sv
tb/sv/first_fit_heap_allocator_checker.sv
tb/sv/tb_first_fit_heap_allocator.sv
